// File: rtl/assert_macros.svh
// Assertion macros for the sorted key jump table RTL.
// Depends on nothing; the including module must have clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge outside reset.
`define SKJT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge outside reset.
`define SKJT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/skjt_pkg.sv
// Shared constants and types for the sorted key jump table.
// Used by the interfaces, the controller, the datapath and the top level.
`default_nettype none

package skjt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int BND_W       = CNT_W + 1;
  localparam int KEY_W       = 32;
  localparam int TGT_W       = 32;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_START,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_LK_PROBE,
    ST_LK_CMP,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RD_POS,
    CMD_SHIFT,
    CMD_PUT,
    CMD_FULL,
    CMD_RD_MID,
    CMD_GO_RIGHT,
    CMD_GO_LEFT,
    CMD_HIT,
    CMD_MISS,
    CMD_EMIT
  } cmd_e;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TGT_W-1:0]        tgt;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_is_one;
    logic search_done;
    logic rd_gt;
    logic rd_lt;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/skjt_intf.sv
// Valid/ready channel interfaces for requests and results.
// Depends on skjt_pkg for the field widths.
`default_nettype none

interface skjt_in_if;
  logic                             valid;
  logic                             ready;
  logic                             func;
  logic signed [skjt_pkg::KEY_W-1:0] key;
  logic [skjt_pkg::TGT_W-1:0]       jump_target;

  modport source (output valid, output func, output key, output jump_target, input ready);
  modport sink   (input valid, input func, input key, input jump_target, output ready);
endinterface

interface skjt_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [skjt_pkg::TGT_W-1:0] jump_out;
  logic                       overflow;

  modport source (output valid, output found, output jump_out, output overflow, input ready);
  modport sink   (input valid, input found, input jump_out, input overflow, output ready);
endinterface

`default_nettype wire

// File: rtl/skjt_ctrl.sv
// Controller state machine for the sorted key jump table.
// Depends on skjt_pkg; drives commands into skjt_dp and reads its status.
`default_nettype none

module skjt_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_func_i,
  input  wire logic               out_ready_i,
  input  wire skjt_pkg::dp_stat_t stat_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  output skjt_pkg::cmd_e          cmd_o
);

  skjt_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic             in_acc;

  assign out_free = !out_valid_q || out_ready_i;
  assign in_acc   = in_valid_i && (state_q == skjt_pkg::ST_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      skjt_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (in_func_i == skjt_pkg::FUNC_LOOKUP) ? skjt_pkg::ST_LK_PROBE
                                                        : skjt_pkg::ST_INS_START;
        end
      end
      skjt_pkg::ST_INS_START: begin
        if (stat_i.full) begin
          state_d = skjt_pkg::ST_DONE;
        end else if (stat_i.empty) begin
          state_d = skjt_pkg::ST_INS_PUT;
        end else begin
          state_d = skjt_pkg::ST_INS_CMP;
        end
      end
      skjt_pkg::ST_INS_CMP: begin
        if (!stat_i.rd_gt) begin
          state_d = skjt_pkg::ST_DONE;
        end else if (stat_i.pos_is_one) begin
          state_d = skjt_pkg::ST_INS_PUT;
        end
      end
      skjt_pkg::ST_INS_PUT: state_d = skjt_pkg::ST_DONE;
      skjt_pkg::ST_LK_PROBE: begin
        state_d = stat_i.search_done ? skjt_pkg::ST_DONE : skjt_pkg::ST_LK_CMP;
      end
      skjt_pkg::ST_LK_CMP: begin
        state_d = (stat_i.rd_gt || stat_i.rd_lt) ? skjt_pkg::ST_LK_PROBE
                                                 : skjt_pkg::ST_DONE;
      end
      skjt_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = skjt_pkg::ST_IDLE;
        end
      end
      default: state_d = skjt_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o = skjt_pkg::CMD_NONE;
    unique case (state_q)
      skjt_pkg::ST_IDLE: begin
        if (in_acc) begin
          cmd_o = skjt_pkg::CMD_LOAD;
        end
      end
      skjt_pkg::ST_INS_START: begin
        if (stat_i.full) begin
          cmd_o = skjt_pkg::CMD_FULL;
        end else if (!stat_i.empty) begin
          cmd_o = skjt_pkg::CMD_RD_POS;
        end
      end
      skjt_pkg::ST_INS_CMP: begin
        cmd_o = stat_i.rd_gt ? skjt_pkg::CMD_SHIFT : skjt_pkg::CMD_PUT;
      end
      skjt_pkg::ST_INS_PUT: cmd_o = skjt_pkg::CMD_PUT;
      skjt_pkg::ST_LK_PROBE: begin
        cmd_o = stat_i.search_done ? skjt_pkg::CMD_MISS : skjt_pkg::CMD_RD_MID;
      end
      skjt_pkg::ST_LK_CMP: begin
        if (stat_i.rd_lt) begin
          cmd_o = skjt_pkg::CMD_GO_RIGHT;
        end else if (stat_i.rd_gt) begin
          cmd_o = skjt_pkg::CMD_GO_LEFT;
        end else begin
          cmd_o = skjt_pkg::CMD_HIT;
        end
      end
      skjt_pkg::ST_DONE: begin
        if (out_free) begin
          cmd_o = skjt_pkg::CMD_EMIT;
        end
      end
      default: cmd_o = skjt_pkg::CMD_NONE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o == skjt_pkg::CMD_EMIT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_ready_o  = (state_q == skjt_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skjt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/skjt_dp.sv
// Datapath for the sorted key jump table: entry memory, count, bounds, result.
// Depends on skjt_pkg; driven by commands from skjt_ctrl.
`default_nettype none

module skjt_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire skjt_pkg::cmd_e                    cmd_i,
  input  wire logic                              in_func_i,
  input  wire logic signed [skjt_pkg::KEY_W-1:0] in_key_i,
  input  wire logic [skjt_pkg::TGT_W-1:0]        in_tgt_i,
  output skjt_pkg::dp_stat_t                     stat_o,
  output logic                                   found_o,
  output logic [skjt_pkg::TGT_W-1:0]             jump_out_o,
  output logic                                   overflow_o
);

  localparam int IDX_W = skjt_pkg::IDX_W;
  localparam int CNT_W = skjt_pkg::CNT_W;
  localparam int BND_W = skjt_pkg::BND_W;

  skjt_pkg::entry_t mem [skjt_pkg::TABLE_DEPTH];
  skjt_pkg::entry_t rd_q;
  skjt_pkg::entry_t wr_data;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;

  logic [CNT_W-1:0] count_q, pos_q;
  logic [CNT_W-1:0] pos_m1, pos_m2;
  logic signed [BND_W-1:0] lo_q, hi_q;
  logic signed [BND_W:0]   bnd_sum;
  logic [IDX_W-1:0]        mid;
  logic signed [BND_W-1:0] mid_ext;

  logic                              req_func_q;
  logic signed [skjt_pkg::KEY_W-1:0] req_key_q;
  logic [skjt_pkg::TGT_W-1:0]        req_tgt_q;

  logic                       res_found_q, res_ovf_q;
  logic [skjt_pkg::TGT_W-1:0] res_jump_q;
  logic                       out_found_q, out_ovf_q;
  logic [skjt_pkg::TGT_W-1:0] out_jump_q;

  assign pos_m1  = pos_q - CNT_W'(1);
  assign pos_m2  = pos_q - CNT_W'(2);
  // Both bounds are non-negative whenever a probe is issued.
  assign bnd_sum = {lo_q[BND_W-1], lo_q} + {hi_q[BND_W-1], hi_q};
  assign mid     = bnd_sum[IDX_W:1];
  assign mid_ext = $signed({{(BND_W-IDX_W){1'b0}}, mid});

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = mid;
    wr_en   = 1'b0;
    wr_addr = pos_q[IDX_W-1:0];
    wr_data = rd_q;
    unique case (cmd_i)
      skjt_pkg::CMD_RD_POS: begin
        rd_en   = 1'b1;
        rd_addr = pos_m1[IDX_W-1:0];
      end
      skjt_pkg::CMD_SHIFT: begin
        // Move the larger entry up and fetch the one below the new gap.
        rd_en   = 1'b1;
        rd_addr = pos_m2[IDX_W-1:0];
        wr_en   = 1'b1;
      end
      skjt_pkg::CMD_PUT: begin
        wr_en       = 1'b1;
        wr_data.key = req_key_q;
        wr_data.tgt = req_tgt_q;
      end
      skjt_pkg::CMD_RD_MID: rd_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i == skjt_pkg::CMD_PUT) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      skjt_pkg::CMD_LOAD: begin
        req_func_q <= in_func_i;
        req_key_q  <= in_key_i;
        req_tgt_q  <= in_tgt_i;
        pos_q      <= count_q;
        lo_q       <= '0;
        hi_q       <= $signed({1'b0, count_q}) - BND_W'(1);
      end
      skjt_pkg::CMD_SHIFT: pos_q <= pos_m1;
      skjt_pkg::CMD_GO_RIGHT: lo_q <= mid_ext + BND_W'(1);
      skjt_pkg::CMD_GO_LEFT:  hi_q <= mid_ext - BND_W'(1);
      skjt_pkg::CMD_PUT: begin
        res_found_q <= 1'b1;
        res_jump_q  <= '0;
        res_ovf_q   <= 1'b0;
      end
      skjt_pkg::CMD_FULL: begin
        res_found_q <= 1'b0;
        res_jump_q  <= '0;
        res_ovf_q   <= 1'b1;
      end
      skjt_pkg::CMD_HIT: begin
        res_found_q <= 1'b1;
        res_jump_q  <= rd_q.tgt;
        res_ovf_q   <= 1'b0;
      end
      skjt_pkg::CMD_MISS: begin
        res_found_q <= 1'b0;
        res_jump_q  <= '0;
        res_ovf_q   <= 1'b0;
      end
      skjt_pkg::CMD_EMIT: begin
        out_found_q <= res_found_q;
        out_jump_q  <= res_jump_q;
        out_ovf_q   <= res_ovf_q;
      end
      default: ;
    endcase
  end

  assign stat_o.full        = (count_q == CNT_W'(skjt_pkg::TABLE_DEPTH));
  assign stat_o.empty       = (count_q == '0);
  assign stat_o.pos_is_one  = (pos_q == CNT_W'(1));
  assign stat_o.search_done = (lo_q > hi_q) || (req_func_q != skjt_pkg::FUNC_LOOKUP);
  assign stat_o.rd_gt       = (rd_q.key > req_key_q);
  assign stat_o.rd_lt       = (rd_q.key < req_key_q);

  assign found_o    = out_found_q;
  assign jump_out_o = out_jump_q;
  assign overflow_o = out_ovf_q;

endmodule

`default_nettype wire

// File: rtl/sorted_key_jump_table.sv
// Lookup: each binary-search probe is a memory read, then a compare.
// Insert: entries larger than the key shift up one at a time, then the new entry is written.
// One request at a time; a finished result waits in an output register.
// Reset clears the entry count and the handshake state; entries are not cleared.
`default_nettype none
`include "assert_macros.svh"

module sorted_key_jump_table (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  skjt_in_if.sink   in_i,
  skjt_out_if.source out_o
);

  skjt_pkg::cmd_e     cmd;
  skjt_pkg::dp_stat_t stat;
  logic               in_ready;
  logic               out_valid;

  skjt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_func_i   (in_i.func),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  skjt_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_func_i  (in_i.func),
    .in_key_i   (in_i.key),
    .in_tgt_i   (in_i.jump_target),
    .stat_o     (stat),
    .found_o    (out_o.found),
    .jump_out_o (out_o.jump_out),
    .overflow_o (out_o.overflow)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  `SKJT_ASSERT_NEXT(a_one_at_a_time, in_i.valid && in_i.ready, !in_i.ready, "request taken while busy")
  `SKJT_ASSERT_IMPL(a_ovf_not_found, out_o.valid && out_o.overflow, !out_o.found, "overflow with found")
  `SKJT_ASSERT_IMPL(a_jump_needs_hit, out_o.valid && (out_o.jump_out != '0), out_o.found, "target without hit")

endmodule

`default_nettype wire
